@@ sv/address_resolution_cache_unit_macros.svh @@
// Assertion shorthands used by the checker of the address resolution cache.
`ifndef ADDRESS_RESOLUTION_CACHE_UNIT_MACROS_SVH
`define ADDRESS_RESOLUTION_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ARC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arc check failed");

// Next-cycle implication, off while reset is high.
`define ARC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arc check failed");

`endif

@@ sv/arc_pkg.sv @@
package arc_pkg;

  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int LEN_W     = 16;
  localparam int OPC_W     = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd2;

  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_PACKET  = 1'b1;

  // Opcode words as they arrive, before the byte swap (request 1, reply 2).
  localparam logic [OPC_W-1:0] RAW_REQUEST = 16'h0100;
  localparam logic [OPC_W-1:0] RAW_REPLY   = 16'h0200;

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 16'd28;
  localparam logic [MAC_W-1:0] BCAST_MAC     = {MAC_W{1'b1}};

  typedef struct packed {
    logic             op;
    logic [IP_W-1:0]  lookup_ip;
    logic [LEN_W-1:0] frame_length;
    logic [OPC_W-1:0] pkt_operation_raw;
    logic [MAC_W-1:0] pkt_sender_mac;
    logic [IP_W-1:0]  pkt_sender_ip;
    logic [IP_W-1:0]  pkt_target_ip;
  } in_t;

  typedef struct packed {
    logic             resolve_valid;
    logic             resolve_hit;
    logic [MAC_W-1:0] resolved_mac;
    logic             frame_valid;
    logic             frame_is_reply;
    logic [MAC_W-1:0] frame_eth_dest;
    logic [MAC_W-1:0] frame_target_mac;
    logic [IP_W-1:0]  frame_target_ip;
    logic [MAC_W-1:0] frame_sender_mac;
    logic [IP_W-1:0]  frame_sender_ip;
  } out_t;

  typedef struct packed {
    logic [IP_W-1:0]  local_ip;
    logic [MAC_W-1:0] local_mac;
    logic             enable;
  } cfg_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

endpackage

@@ sv/arc_ram.sv @@
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/arc_cfg.sv @@
module arc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arc_pkg::CFG_W-1:0]     cfg_data,
  output arc_pkg::cfg_t                  cfg
);

  import arc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_ip  <= '0;
      cfg.local_mac <= '0;
      cfg.enable    <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOCAL_IP:  cfg.local_ip  <= cfg_data[IP_W-1:0];
        REG_LOCAL_MAC: cfg.local_mac <= cfg_data[MAC_W-1:0];
        REG_ENABLE:    cfg.enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/address_resolution_cache_unit.sv @@
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------
// item in   | start high, busy low | item (arc_pkg::in_t)
// result    | done, one cycle      | result (arc_pkg::out_t)
// config    | cfg_write            | cfg_index, cfg_data
//
// An enabled resolve or a reply word holds busy while it scans the table slots
// below the fill count, one table read per cycle on the single RAM read port;
// a hit ends the scan early. A resolve result shows on done in the cycle after
// busy falls; a reply word gives no result. Requests and dropped words never
// raise busy; a reply frame shows on done in the next cycle. Reset is
// synchronous and clears the fill count; the table needs no sweep. Results
// pulse on done for one cycle and cannot be stalled.
module address_resolution_cache_unit #(
  parameter int TABLE_DEPTH = arc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  arc_pkg::in_t                   item,
  input  logic                           cfg_write,
  input  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arc_pkg::CFG_W-1:0]     cfg_data,
  output logic                           done,
  output arc_pkg::out_t                  result
);

  import arc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  cfg_t cfg;

  logic          state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] rd_addr, rd_addr_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr;
  logic [IP_W-1:0]  key_ip, key_ip_next;
  logic [MAC_W-1:0] key_mac, key_mac_next;
  logic          key_reply, key_reply_next;
  logic          done_next;
  out_t          result_next;

  logic   accept;
  logic   rd_issue;
  logic   match;
  logic   exhausted;
  logic   finish;
  logic   wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;
  entry_t rd_data;

  arc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  assign busy   = (state == ST_SCAN);
  assign accept = start && !busy;

  // Valid entries always form a prefix of the table, so the fill count
  // stands in for per-slot valid bits.
  assign match     = (state == ST_SCAN) && pend && (rd_data.ip == key_ip);
  assign exhausted = (state == ST_SCAN) && !pend && !(rd_addr < fill);
  assign finish    = match || exhausted;
  assign rd_issue  = (state == ST_SCAN) && (rd_addr < fill) && !match;

  assign wr_en        = finish && key_reply && (match || (fill != DEPTH_CNT));
  assign wr_addr      = match ? pend_addr : fill[AW-1:0];
  assign wr_data.ip   = key_ip;
  assign wr_data.mac  = key_mac;

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    rd_addr_next   = rd_addr;
    pend_next      = 1'b0;
    key_ip_next    = key_ip;
    key_mac_next   = key_mac;
    key_reply_next = key_reply;
    done_next      = 1'b0;
    result_next    = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.op == OP_RESOLVE) begin
            if (cfg.enable) begin
              state_next     = ST_SCAN;
              rd_addr_next   = '0;
              key_ip_next    = item.lookup_ip;
              key_reply_next = 1'b0;
            end
          end else if (item.frame_length >= MIN_FRAME_LEN) begin
            if (item.pkt_operation_raw == RAW_REPLY) begin
              state_next     = ST_SCAN;
              rd_addr_next   = '0;
              key_ip_next    = item.pkt_sender_ip;
              key_mac_next   = item.pkt_sender_mac;
              key_reply_next = 1'b1;
            end else if (item.pkt_operation_raw == RAW_REQUEST &&
                         item.pkt_target_ip == cfg.local_ip) begin
              done_next                    = 1'b1;
              result_next.frame_valid      = 1'b1;
              result_next.frame_is_reply   = 1'b1;
              result_next.frame_eth_dest   = item.pkt_sender_mac;
              result_next.frame_target_mac = item.pkt_sender_mac;
              result_next.frame_target_ip  = item.pkt_sender_ip;
              result_next.frame_sender_mac = cfg.local_mac;
              result_next.frame_sender_ip  = cfg.local_ip;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_issue) begin
          rd_addr_next = rd_addr + 1'b1;
          pend_next    = 1'b1;
        end
        if (finish) begin
          state_next = ST_IDLE;
          pend_next  = 1'b0;
          if (key_reply) begin
            // Claim the next free slot unless the address is already held.
            if (!match && fill != DEPTH_CNT) begin
              fill_next = fill + 1'b1;
            end
          end else if (match) begin
            done_next                 = 1'b1;
            result_next.resolve_valid = 1'b1;
            result_next.resolve_hit   = 1'b1;
            result_next.resolved_mac  = rd_data.mac;
          end else begin
            done_next                    = 1'b1;
            result_next.resolve_valid    = 1'b1;
            result_next.resolved_mac     = BCAST_MAC;
            result_next.frame_valid      = 1'b1;
            result_next.frame_eth_dest   = BCAST_MAC;
            result_next.frame_target_ip  = key_ip;
            result_next.frame_sender_mac = cfg.local_mac;
            result_next.frame_sender_ip  = cfg.local_ip;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr   <= rd_addr_next;
    pend_addr <= rd_addr[AW-1:0];
    key_ip    <= key_ip_next;
    key_mac   <= key_mac_next;
    key_reply <= key_reply_next;
    result    <= result_next;
  end

endmodule

@@ sv/arc_checker.sv @@
`include "address_resolution_cache_unit_macros.svh"

module arc_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input arc_pkg::in_t  item,
  input logic          done,
  input arc_pkg::out_t result
);

  import arc_pkg::*;

  // Every word on the result port carries an answer or a frame.
  `ARC_ASSERT_IMP(a_done_has_payload, done, result.resolve_valid || result.frame_valid)

  // A hit answers from the table and sends nothing.
  `ARC_ASSERT_IMP(a_hit_no_frame, done && result.resolve_hit,
                  result.resolve_valid && !result.frame_valid)

  // A broadcast request only follows a resolve miss.
  `ARC_ASSERT_IMP(a_request_shape,
                  done && result.frame_valid && !result.frame_is_reply,
                  result.resolve_valid && result.frame_eth_dest == BCAST_MAC &&
                  result.frame_target_mac == '0)

  // Drop short packets without raising busy or pulsing done.
  `ARC_ASSERT_NXT(a_short_drop,
                  start && !busy && item.op == OP_PACKET &&
                  item.frame_length < MIN_FRAME_LEN,
                  !busy && !done)

endmodule

bind address_resolution_cache_unit arc_checker u_arc_checker (.*);

@@ bench/address_resolution_cache_unit_tb.sv @@
module address_resolution_cache_unit_tb;
  import arc_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 180;
  localparam int POOL_N = 96;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {W_RESOLVE, W_LEARN, W_ASK, W_NOISE} word_kind_e;

  // Mirror of the ARP table plus the queue of answers still to come out.
  class arp_table_scoreboard;
    logic [IP_W-1:0]  slot_ip  [DEPTH];
    logic [MAC_W-1:0] slot_mac [DEPTH];
    bit               slot_used[DEPTH];
    cfg_t             cfg;
    out_t             answers[$];
    int n_err, n_results, n_hits, n_misses, n_replies_sent, n_learned, n_full_drops;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_ip[i] = '0;
        slot_mac[i] = '0;
        slot_used[i] = 1'b0;
      end
      cfg = '0;
      cfg.enable = 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_LOCAL_IP:  cfg.local_ip = d[IP_W-1:0];
        REG_LOCAL_MAC: cfg.local_mac = d[MAC_W-1:0];
        REG_ENABLE:    cfg.enable = d[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void note_word(in_t w);
      out_t r;
      int slot;
      r = '0;
      slot = -1;
      if (w.op == OP_RESOLVE) begin
        if (!cfg.enable) return;
        r.resolve_valid = 1'b1;
        for (int i = 0; i < DEPTH && slot < 0; i++)
          if (slot_used[i] && slot_ip[i] == w.lookup_ip) slot = i;
        if (slot >= 0) begin
          r.resolve_hit = 1'b1;
          r.resolved_mac = slot_mac[slot];
          n_hits++;
        end else begin
          // miss: broadcast answer plus an ARP request for the address
          r.resolved_mac = BCAST_MAC;
          r.frame_valid = 1'b1;
          r.frame_is_reply = 1'b0;
          r.frame_eth_dest = BCAST_MAC;
          r.frame_target_mac = '0;
          r.frame_target_ip = w.lookup_ip;
          r.frame_sender_mac = cfg.local_mac;
          r.frame_sender_ip = cfg.local_ip;
          n_misses++;
        end
        answers.push_back(r);
        return;
      end
      if (w.frame_length < MIN_FRAME_LEN) return;
      if (w.pkt_operation_raw == RAW_REPLY) begin
        for (int i = 0; i < DEPTH && slot < 0; i++)
          if (!slot_used[i] || slot_ip[i] == w.pkt_sender_ip) slot = i;
        if (slot >= 0) begin
          slot_ip[slot] = w.pkt_sender_ip;
          slot_mac[slot] = w.pkt_sender_mac;
          slot_used[slot] = 1'b1;
          n_learned++;
        end else begin
          n_full_drops++;
        end
        return;
      end
      if (w.pkt_operation_raw == RAW_REQUEST && w.pkt_target_ip == cfg.local_ip) begin
        r.frame_valid = 1'b1;
        r.frame_is_reply = 1'b1;
        r.frame_eth_dest = w.pkt_sender_mac;
        r.frame_target_mac = w.pkt_sender_mac;
        r.frame_target_ip = w.pkt_sender_ip;
        r.frame_sender_mac = cfg.local_mac;
        r.frame_sender_ip = cfg.local_ip;
        n_replies_sent++;
        answers.push_back(r);
      end
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        n_err++;
        $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (answers.size() == 0) begin
        n_err++;
        $display("%0t unexpected result: expected none, got %h", $time, got);
        return;
      end
      want = answers.pop_front();
      n_results++;
      cmp("resolve_valid", want.resolve_valid, got.resolve_valid);
      cmp("resolve_hit", want.resolve_hit, got.resolve_hit);
      cmp("resolved_mac", want.resolved_mac, got.resolved_mac);
      cmp("frame_valid", want.frame_valid, got.frame_valid);
      cmp("frame_is_reply", want.frame_is_reply, got.frame_is_reply);
      cmp("frame_eth_dest", want.frame_eth_dest, got.frame_eth_dest);
      cmp("frame_target_mac", want.frame_target_mac, got.frame_target_mac);
      cmp("frame_target_ip", want.frame_target_ip, got.frame_target_ip);
      cmp("frame_sender_mac", want.frame_sender_mac, got.frame_sender_mac);
      cmp("frame_sender_ip", want.frame_sender_ip, got.frame_sender_ip);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_t                  item;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  out_t                 result;

  arp_table_scoreboard sb = new();
  logic [IP_W-1:0] ip_pool[POOL_N];
  int stall_cycles = 0;

  address_resolution_cache_unit #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always #4 clk = ~clk;

  // Check results before noting the word taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_word(item);
    end
    if ((start && !busy) || done || cfg_write) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: nothing moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [MAC_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic in_t resolve_word(logic [IP_W-1:0] ip);
    in_t w;
    w.op = OP_RESOLVE;
    w.lookup_ip = ip;
    w.frame_length = 16'($urandom);
    w.pkt_operation_raw = 16'($urandom);
    w.pkt_sender_mac = rand48();
    w.pkt_sender_ip = $urandom;
    w.pkt_target_ip = $urandom;
    return w;
  endfunction

  function automatic in_t packet_word(logic [OPC_W-1:0] raw, logic [LEN_W-1:0] len,
                                      logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                                      logic [IP_W-1:0] tip);
    in_t w;
    w.op = OP_PACKET;
    w.lookup_ip = $urandom;
    w.frame_length = len;
    w.pkt_operation_raw = raw;
    w.pkt_sender_mac = smac;
    w.pkt_sender_ip = sip;
    w.pkt_target_ip = tip;
    return w;
  endfunction

  function automatic in_t make_word(word_kind_e k, int pool_n);
    logic [IP_W-1:0]  ip;
    logic [LEN_W-1:0] len;
    ip = ip_pool[$urandom_range(0, pool_n - 1)];
    len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, MIN_FRAME_LEN - 1))
                                      : LEN_W'($urandom_range(MIN_FRAME_LEN, 16'hFFFF));
    case (k)
      W_RESOLVE: return resolve_word(($urandom_range(0, 4) != 0) ? ip : IP_W'($urandom));
      W_LEARN:   return packet_word(RAW_REPLY, len, rand48(), ip, $urandom);
      W_ASK:     return packet_word(RAW_REQUEST, len, rand48(),
                                    ($urandom_range(0, 1) != 0) ? ip : IP_W'($urandom),
                                    ($urandom_range(0, 3) != 0) ? sb.cfg.local_ip
                                                                : IP_W'($urandom));
      default:   return packet_word(16'($urandom), 16'($urandom), rand48(),
                                    $urandom, $urandom);
    endcase
  endfunction

  // Hold start high until the word is taken; leave start high on return.
  task automatic send_word(input in_t w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
  endtask

  // Wait out every pending answer, then the extra margin, then busy.
  task automatic drain(input int extra);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic set_config(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                            input logic en, input bit junk);
    logic [CFG_W-1:0] d;
    drain(DEPTH + 2);
    write_reg(REG_LOCAL_IP, {16'($urandom), ip});
    write_reg(REG_LOCAL_MAC, mac);
    d = rand48();
    d[0] = en;
    write_reg(REG_ENABLE, d);
    if (junk) write_reg(REG_UNUSED, rand48());
    cfg_write <= 1'b0;
  endtask

  initial begin
    int pool_sizes[PHASES];
    int r;
    int gap;
    bit idle_on;
    word_kind_e k;

    pool_sizes = '{24, 40, 56, 72, 96, 96};
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int i = 0; i < POOL_N; i++) ip_pool[i] = $urandom;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: boundaries, every opcode path, table updates, disabled resolve
    send_word(resolve_word('0), 0);
    send_word(resolve_word('1), 0);
    send_word(packet_word(RAW_REPLY, MIN_FRAME_LEN, BCAST_MAC, 32'h0A00_0001, '0), 0);
    send_word(packet_word(RAW_REPLY, MIN_FRAME_LEN - 1, rand48(), 32'h0A00_0002, '0), 0);
    send_word(resolve_word(32'h0A00_0001), 0);
    send_word(resolve_word(32'h0A00_0002), 2);
    send_word(packet_word(RAW_REQUEST, 16'hFFFF, rand48(), 32'hC0A8_0005, '0), 0);
    send_word(packet_word(RAW_REQUEST, 16'd60, rand48(), 32'hC0A8_0005, 32'h0A00_0009), 0);
    send_word(packet_word(16'h0001, 16'd60, rand48(), 32'hC0A8_0006, '0), 0);
    send_word(packet_word(16'hFFFF, 16'd60, rand48(), 32'hC0A8_0006, '0), 0);
    send_word(packet_word(RAW_REQUEST, 16'd0, rand48(), 32'hC0A8_0007, '0), 0);
    send_word(packet_word(RAW_REPLY, 16'd64, 48'h1234_5678_9ABC, 32'h0A00_0001, '0), 0);
    send_word(resolve_word(32'h0A00_0001), 0);
    send_word(packet_word(RAW_REPLY, 16'hFFFF, '0, '1, '0), 1);
    send_word(resolve_word('1), 0);
    send_word(resolve_word('0), 0);
    set_config('1, '1, 1'b0, 1'b1);
    send_word(resolve_word(32'h0A00_0001), 0);
    send_word(packet_word(RAW_REQUEST, 16'd42, rand48(), 32'hC0A8_0008, '1), 0);
    send_word(packet_word(RAW_REPLY, 16'd42, rand48(), '0, '0), 0);
    set_config($urandom, rand48(), 1'b1, 1'b0);
    send_word(resolve_word('0), 0);
    send_word(resolve_word(32'h0A00_0002), 0);

    // random: learn, resolve and answer over a growing address pool
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config($urandom, rand48(), 1'b1, 1'b0);
        1: set_config('0, '0, 1'b1, 1'b1);
        2: set_config($urandom, rand48(), 1'b0, 1'b0);
        3: set_config('1, '1, 1'b1, 1'b0);
        default: set_config($urandom, rand48(), 1'b1, 1'b0);
      endcase
      idle_on = 1'b1;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 30 == 0) idle_on = (p < PHASES - 1) && ($urandom_range(0, 1) != 0);
        r = $urandom_range(0, 99);
        if (r < 38) k = W_RESOLVE;
        else if (r < 68) k = W_LEARN;
        else if (r < 90) k = W_ASK;
        else k = W_NOISE;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
        send_word(make_word(k, pool_sizes[p]), gap);
      end
    end

    drain(DEPTH + 4);
    $display("checked %0d results: %0d resolve hits, %0d misses, %0d ARP replies sent",
             sb.n_results, sb.n_hits, sb.n_misses, sb.n_replies_sent);
    $display("table took %0d learned entries and dropped %0d replies while full",
             sb.n_learned, sb.n_full_drops);
    if (sb.n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ address_resolution_cache_unit.f @@
+incdir+sv
sv/arc_pkg.sv
sv/arc_ram.sv
sv/arc_cfg.sv
sv/address_resolution_cache_unit.sv
sv/arc_checker.sv
bench/address_resolution_cache_unit_tb.sv
